>>> rtl/adcavg_pkg.sv
// Shared types, codes and constants of the ADC scan channel averager.
`default_nettype none

package adcavg_pkg;

   localparam int SUM_W                = 24;
   localparam int CNT_W                = 9;
   localparam int CNT_STORE_W          = 8;
   localparam int CHAN_W               = 5;
   localparam int SAMPLE_W             = 16;
   localparam int FLAGS_W              = 32;
   localparam int CSR_DATA_W           = 9;
   localparam int CSR_INDEX_W          = 3;
   localparam int DEFAULT_NUM_CHANNELS = 32;

   localparam logic [CNT_W-1:0] AVG_MAX = 9'd256;

   typedef enum logic [1:0] {
      OP_FLAGS  = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_READ   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STS_OK           = 2'd0,
      STS_NO_BUFFER    = 2'd1,
      STS_OUT_OF_RANGE = 2'd2,
      STS_NO_DATA      = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DIFFERENTIAL = 3'd0,
      CSR_FIRST_CHAN   = 3'd1,
      CSR_LAST_CHAN    = 3'd2,
      CSR_AVG_COUNT    = 3'd3,
      CSR_RESTART      = 3'd4,
      CSR_CONTINUOUS   = 3'd5
   } csr_index_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic out_busy;
   } dp_status_type;

endpackage

`default_nettype wire

>>> rtl/adcavg_dp.sv
// Datapath of the ADC scan channel averager: settings, sum store and result register.
`default_nettype none

module adcavg_dp
   import adcavg_pkg::*;
#(
   parameter int NUM_CHANNELS = DEFAULT_NUM_CHANNELS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data,
   input  wire logic [1:0]             req_op,
   input  wire logic [SAMPLE_W-1:0]    req_flags_low,
   input  wire logic [SAMPLE_W-1:0]    req_flags_high,
   input  wire logic [CHAN_W-1:0]      req_chan,
   input  wire logic [SAMPLE_W-1:0]    req_sample_first,
   input  wire logic [SAMPLE_W-1:0]    req_sample_second,
   input  wire ctrl_cmd_type           cmd,
   output      dp_status_type          stat,
   input  wire logic                   rsp_ready,
   output      logic                   rsp_valid,
   output      logic [1:0]             rsp_status,
   output      logic                   rsp_average_done,
   output      logic                   rsp_restart_request,
   output      logic [SUM_W-1:0]       rsp_sum_out,
   output      logic [CNT_W-1:0]       rsp_count_out
);

   localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [CHAN_W-1:0] TOP_CHAN = CHAN_W'(NUM_CHANNELS - 1);

   // Settings
   logic                  diff_ff;
   logic [CHAN_W-1:0]     first_ff;
   logic [CHAN_W-1:0]     last_ff;
   logic [CNT_W-1:0]      avg_ff;
   logic                  restart_ff;
   logic                  cont_ff;

   // Captured item
   op_type                op_ff;
   logic [FLAGS_W-1:0]    flags_ff;
   logic [CHAN_W-1:0]     chan_ff;
   logic [SAMPLE_W-1:0]   s0_ff;
   logic [SAMPLE_W-1:0]   s1_ff;

   // Store and its registered read
   logic [SUM_W-1:0]       sum_mem [NUM_CHANNELS];
   logic [CNT_STORE_W-1:0] cnt_mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] valid_ff;
   logic [SUM_W-1:0]       rd_sum_ff;
   logic [CNT_STORE_W-1:0] rd_cnt_ff;
   logic                   rd_valid_ff;

   logic                  b0_ff;
   logic                  b1_ff;

   // Result register
   logic                  out_valid_ff;
   logic                  out_valid_in;
   status_type            out_status_ff;
   logic                  out_done_ff;
   logic                  out_restart_ff;
   logic [SUM_W-1:0]      out_sum_ff;
   logic [CNT_W-1:0]      out_cnt_ff;

   logic [ADDR_W-1:0]     rd_addr;
   logic [ADDR_W-1:0]     wr_addr;
   logic [CHAN_W-1:0]     eff_last;
   logic                  range_empty;
   logic                  chan_in_range;
   logic [FLAGS_W-1:0]    mask;
   logic                  new_b0;
   logic                  new_b1;
   logic [CNT_W-1:0]      eff_avg;
   logic [CNT_W-1:0]      cur_cnt;
   logic                  fresh;
   logic [SUM_W-1:0]      base_sum;
   logic [CNT_W-1:0]      base_cnt;
   logic                  add0;
   logic                  add1;
   logic [SUM_W-1:0]      sum1;
   logic [CNT_W-1:0]      cnt1;
   logic [SUM_W-1:0]      sum2;
   logic [CNT_W-1:0]      cnt2;

   status_type            res_status;
   logic                  res_done;
   logic                  res_restart;
   logic [SUM_W-1:0]      res_sum;
   logic [CNT_W-1:0]      res_cnt;
   logic                  res_write;
   logic                  res_flags;

   assign rd_addr = req_chan[ADDR_W-1:0];
   assign wr_addr = chan_ff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_ff    <= 1'b0;
         first_ff   <= '0;
         last_ff    <= '0;
         avg_ff     <= CNT_W'(1);
         restart_ff <= 1'b0;
         cont_ff    <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_DIFFERENTIAL: diff_ff    <= csr_write_data[0];
            CSR_FIRST_CHAN:   first_ff   <= csr_write_data[CHAN_W-1:0];
            CSR_LAST_CHAN:    last_ff    <= csr_write_data[CHAN_W-1:0];
            CSR_AVG_COUNT:    avg_ff     <= csr_write_data[CNT_W-1:0];
            CSR_RESTART:      restart_ff <= csr_write_data[0];
            CSR_CONTINUOUS:   cont_ff    <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Hold the item and read the store at the accepted channel.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= op_type'(req_op);
         flags_ff    <= {req_flags_high, req_flags_low};
         chan_ff     <= req_chan;
         s0_ff       <= req_sample_first;
         s1_ff       <= req_sample_second;
         rd_sum_ff   <= sum_mem[rd_addr];
         rd_cnt_ff   <= cnt_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && res_write) begin
         sum_mem[wr_addr] <= res_sum;
         cnt_mem[wr_addr] <= CNT_STORE_W'(res_cnt - CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         b0_ff    <= 1'b0;
         b1_ff    <= 1'b0;
      end else if (cmd.commit) begin
         if (res_write) valid_ff[wr_addr] <= 1'b1;
         if (res_flags) begin
            b0_ff <= new_b0;
            b1_ff <= new_b1;
         end
      end
   end

   // Scan range and mask
   assign eff_last      = (last_ff > TOP_CHAN) ? TOP_CHAN : last_ff;
   assign range_empty   = first_ff > eff_last;
   assign chan_in_range = !range_empty && (chan_ff >= first_ff) && (chan_ff <= eff_last);

   always_comb begin
      for (int i = 0; i < FLAGS_W; i++) begin
         mask[i] = (CHAN_W'(i) >= first_ff) && (CHAN_W'(i) <= eff_last);
      end
   end

   always_comb begin
      if (range_empty) begin
         new_b0 = 1'b0;
         new_b1 = 1'b0;
      end else if (diff_ff) begin
         new_b0 = (({16'b0, flags_ff[15:0]}) & mask) == mask;
         new_b1 = (({16'b0, flags_ff[31:16]}) & mask) == mask;
      end else begin
         new_b0 = (flags_ff & mask) == mask;
         new_b1 = 1'b0;
      end
   end

   // Accumulate
   assign eff_avg  = (avg_ff == '0) ? CNT_W'(1) : ((avg_ff > AVG_MAX) ? AVG_MAX : avg_ff);
   assign cur_cnt  = {1'b0, rd_cnt_ff} + CNT_W'(1);
   assign fresh    = !rd_valid_ff || (cur_cnt >= eff_avg);
   assign base_sum = fresh ? '0 : rd_sum_ff;
   assign base_cnt = fresh ? '0 : cur_cnt;
   assign add0     = b0_ff && (base_cnt < eff_avg);
   assign sum1     = base_sum + (add0 ? SUM_W'(s0_ff) : '0);
   assign cnt1     = base_cnt + CNT_W'(add0);
   assign add1     = b1_ff && (cnt1 < eff_avg);
   assign sum2     = sum1 + (add1 ? SUM_W'(s1_ff) : '0);
   assign cnt2     = cnt1 + CNT_W'(add1);

   always_comb begin
      res_status  = STS_OK;
      res_done    = 1'b0;
      res_restart = 1'b0;
      res_sum     = '0;
      res_cnt     = '0;
      res_write   = 1'b0;
      res_flags   = 1'b0;
      case (op_ff)
         OP_FLAGS: begin
            res_flags  = 1'b1;
            res_status = (new_b0 || new_b1) ? STS_OK : STS_NO_BUFFER;
         end
         OP_SAMPLE: begin
            if (!chan_in_range) begin
               res_status = STS_OUT_OF_RANGE;
            end else if (!b0_ff && !b1_ff) begin
               res_status = STS_NO_BUFFER;
            end else begin
               res_write = 1'b1;
               res_sum   = sum2;
               res_cnt   = cnt2;
               if ((cnt2 >= eff_avg) && (chan_ff == eff_last)) begin
                  res_done    = 1'b1;
                  res_restart = restart_ff && cont_ff;
               end
            end
         end
         OP_READ: begin
            if (!chan_in_range) begin
               res_status = STS_OUT_OF_RANGE;
            end else if (!rd_valid_ff) begin
               res_status = STS_NO_DATA;
            end else begin
               res_sum = rd_sum_ff;
               res_cnt = cur_cnt;
            end
         end
         default: ;
      endcase
   end

   // Result register
   always_comb begin
      if (cmd.commit) out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
      else out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_status_ff  <= res_status;
         out_done_ff    <= res_done;
         out_restart_ff <= res_restart;
         out_sum_ff     <= res_sum;
         out_cnt_ff     <= res_cnt;
      end
   end

   assign stat.out_busy       = out_valid_ff && !rsp_ready;
   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_status_ff;
   assign rsp_average_done    = out_done_ff;
   assign rsp_restart_request = out_restart_ff;
   assign rsp_sum_out         = out_sum_ff;
   assign rsp_count_out       = out_cnt_ff;

   a_commit_loads: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> out_valid_ff)
      else $error("result register not loaded after commit");

   a_restart_needs_done: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_restart_ff) |-> out_done_ff)
      else $error("restart request without average done");

   a_done_is_ok: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_done_ff) |-> (out_status_ff == STS_OK))
      else $error("average done on a failed item");

   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && res_write) |=> valid_ff[$past(wr_addr)])
      else $error("channel not marked valid after update");

endmodule

`default_nettype wire

>>> rtl/adcavg_ctrl.sv
// Controller of the ADC scan channel averager: item sequencing state machine.
`default_nettype none

module adcavg_ctrl
   import adcavg_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   input  wire dp_status_type stat,
   output      ctrl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            // hold off new items while reset is applied
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            // hold until the result register can take the item
            if (!stat.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   a_capture_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == S_EXEC))
      else $error("capture did not advance to execute");

   a_commit_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (state_ff == S_IDLE))
      else $error("commit did not return to idle");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      !(cmd.capture && cmd.commit))
      else $error("capture and commit in the same cycle");

endmodule

`default_nettype wire

>>> rtl/adc_scan_channel_averager_core.sv
// Top level of the ADC scan channel averager: controller plus datapath.
`default_nettype none

// Per-channel averaging store for a multi-channel ADC scan. Each request item
// is a flags event (records which result buffers are complete against the
// first..last channel mask), a sample (adds one or two samples into the
// channel's 24-bit wrapping sum, restarting the sum once the average count is
// reached) or a read (returns sum and count). Every item yields exactly one
// response item. The idle state takes an item with a registered read of the
// per-channel sum store; the execute state updates the store and loads the
// response register, waiting while a response is held and rsp_ready is low.
// No new item is taken before that. The response register decouples the two
// sides: a new item is taken while the previous response still waits.
// Settings are written through the csr_ port at any time the block is idle
// and take effect on the next item; writing them never clears stored sums.

module adc_scan_channel_averager_core
   import adcavg_pkg::*;
#(
   parameter int NUM_CHANNELS = DEFAULT_NUM_CHANNELS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire logic [1:0]             req_op,
   input  wire logic [SAMPLE_W-1:0]    req_flags_low,
   input  wire logic [SAMPLE_W-1:0]    req_flags_high,
   input  wire logic [CHAN_W-1:0]      req_chan,
   input  wire logic [SAMPLE_W-1:0]    req_sample_first,
   input  wire logic [SAMPLE_W-1:0]    req_sample_second,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic [1:0]             rsp_status,
   output      logic                   rsp_average_done,
   output      logic                   rsp_restart_request,
   output      logic [SUM_W-1:0]       rsp_sum_out,
   output      logic [CNT_W-1:0]       rsp_count_out
);

   ctrl_cmd_type  cmd;
   dp_status_type stat;

   // Sequence items: capture on accept, commit once the response slot frees.
   adcavg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Settings, sum store, accumulate logic and response register.
   adcavg_dp #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_op              (req_op),
      .req_flags_low       (req_flags_low),
      .req_flags_high      (req_flags_high),
      .req_chan            (req_chan),
      .req_sample_first    (req_sample_first),
      .req_sample_second   (req_sample_second),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_average_done    (rsp_average_done),
      .rsp_restart_request (rsp_restart_request),
      .rsp_sum_out         (rsp_sum_out),
      .rsp_count_out       (rsp_count_out)
   );

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the ADC scan channel averager core.
`timescale 1ns / 1ps

module testbench;
   import adcavg_pkg::*;

   localparam int NUM_CH        = DEFAULT_NUM_CHANNELS;
   localparam int NUM_PHASES    = 12;
   localparam int PHASE_ITEMS   = 162;
   localparam int STALL_PHASE   = 8;
   localparam int STALL_CYCLES  = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_PRINTS    = 50;
   localparam logic [1:0] OP_SPARE = 2'd3;

   // One request item, field for field as it goes onto the req_ ports.
   typedef struct packed {
      logic [1:0]          op;
      logic [SAMPLE_W-1:0] flags_low;
      logic [SAMPLE_W-1:0] flags_high;
      logic [CHAN_W-1:0]   chan;
      logic [SAMPLE_W-1:0] sample_first;
      logic [SAMPLE_W-1:0] sample_second;
   } scan_req_type;

   typedef struct packed {
      status_type       status;
      logic             done;
      logic             restart;
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
   } scan_result_type;

   typedef struct packed {
      logic             diff;
      logic [4:0]       first;
      logic [4:0]       last;
      logic [8:0]       avg;
      logic             restart;
      logic             continuous;
   } scan_settings_type;

   // A directed row either loads a full set of registers or offers one item.
   typedef struct packed {
      bit                is_settings;
      scan_settings_type cfg;
      scan_req_type      item;
      bit                typed;
      scan_result_type   want;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_op = '0;
   logic [SAMPLE_W-1:0]    req_flags_low = '0;
   logic [SAMPLE_W-1:0]    req_flags_high = '0;
   logic [CHAN_W-1:0]      req_chan = '0;
   logic [SAMPLE_W-1:0]    req_sample_first = '0;
   logic [SAMPLE_W-1:0]    req_sample_second = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [1:0]             rsp_status;
   logic                   rsp_average_done;
   logic                   rsp_restart_request;
   logic [SUM_W-1:0]       rsp_sum_out;
   logic [CNT_W-1:0]       rsp_count_out;

   // Predictor state: per-channel sums and counts, buffer flags, registers.
   logic [SUM_W-1:0]       sum_store [NUM_CH];
   logic [CNT_STORE_W-1:0] count_less_one_store [NUM_CH];
   bit                     has_data [NUM_CH];
   bit                     buf0_complete;
   bit                     buf1_complete;
   scan_settings_type      active_cfg;

   scan_result_type pending_results [$];
   stim_row_type    directed_rows [$];
   scan_result_type blank_result = '0;

   int mismatch_count  = 0;
   int send_idle_pct   = 0;
   int recv_idle_pct   = 0;
   int long_stall_left = 0;

   adc_scan_channel_averager_core #(.NUM_CHANNELS(NUM_CH)) dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_flags_low       (req_flags_low),
      .req_flags_high      (req_flags_high),
      .req_chan            (req_chan),
      .req_sample_first    (req_sample_first),
      .req_sample_second   (req_sample_second),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_average_done    (rsp_average_done),
      .rsp_restart_request (rsp_restart_request),
      .rsp_sum_out         (rsp_sum_out),
      .rsp_count_out       (rsp_count_out)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs on a handshake.
   initial begin
      #4_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Clip the last channel to the store size.
   function automatic int eff_last();
      return (active_cfg.last > NUM_CH - 1) ? NUM_CH - 1 : int'(active_cfg.last);
   endfunction

   function automatic bit range_empty();
      return int'(active_cfg.first) > eff_last();
   endfunction

   function automatic logic [31:0] scan_mask();
      logic [31:0] m;
      for (int i = 0; i < 32; i++)
         m[i] = (i >= int'(active_cfg.first)) && (i <= eff_last());
      return m;
   endfunction

   // Work out the result of one item and advance the channel store.
   task automatic compute_scan_result(input scan_req_type it,
                                      output scan_result_type res);
      logic [31:0] m;
      logic [31:0] all;
      int          avg;
      int          cnt;
      int          acc;
      bit          in_rng;
      res    = '0;
      m      = scan_mask();
      in_rng = !range_empty() && int'(it.chan) >= int'(active_cfg.first)
               && int'(it.chan) <= eff_last();
      // Average count of zero acts as one; anything past 256 saturates.
      if (active_cfg.avg == 0)
         avg = 1;
      else if (active_cfg.avg > AVG_MAX)
         avg = 256;
      else
         avg = int'(active_cfg.avg);

      case (it.op)
         OP_FLAGS: begin
            if (range_empty()) begin
               buf0_complete = 0;
               buf1_complete = 0;
            end else if (active_cfg.diff) begin
               // A mask reaching above bit 15 can never match a 16-bit half.
               buf0_complete = (m[31:16] == 0) && ((it.flags_low & m[15:0]) == m[15:0]);
               buf1_complete = (m[31:16] == 0) && ((it.flags_high & m[15:0]) == m[15:0]);
            end else begin
               all = {it.flags_high, it.flags_low};
               buf0_complete = (all & m) == m;
               buf1_complete = 0;
            end
            res.status = (buf0_complete || buf1_complete) ? STS_OK : STS_NO_BUFFER;
         end
         OP_SAMPLE: begin
            if (!in_rng)
               res.status = STS_OUT_OF_RANGE;
            else if (!buf0_complete && !buf1_complete)
               res.status = STS_NO_BUFFER;
            else begin
               acc = int'(sum_store[it.chan]);
               cnt = int'(count_less_one_store[it.chan]) + 1;
               // Start a fresh sum on first use or once the average is full.
               if (!has_data[it.chan] || cnt >= avg) begin
                  acc = 0;
                  cnt = 0;
               end
               if (buf0_complete && cnt + 1 <= avg) begin
                  acc += int'(it.sample_first);
                  cnt++;
               end
               if (buf1_complete && cnt + 1 <= avg) begin
                  acc += int'(it.sample_second);
                  cnt++;
               end
               sum_store[it.chan]            = acc[SUM_W-1:0];
               count_less_one_store[it.chan] = CNT_STORE_W'(cnt - 1);
               has_data[it.chan]             = 1;
               res.status = STS_OK;
               res.sum    = acc[SUM_W-1:0];
               res.count  = CNT_W'(cnt);
               if (cnt >= avg && int'(it.chan) == eff_last()) begin
                  res.done    = 1'b1;
                  res.restart = active_cfg.restart && active_cfg.continuous;
               end
            end
         end
         OP_READ: begin
            if (!in_rng)
               res.status = STS_OUT_OF_RANGE;
            else if (!has_data[it.chan])
               res.status = STS_NO_DATA;
            else begin
               res.status = STS_OK;
               res.sum    = sum_store[it.chan];
               res.count  = CNT_W'(count_less_one_store[it.chan] + 1);
            end
         end
         default: res = '0;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Hold the write enable high; the caller lowers it after the last write.
   task automatic put_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
   endtask

   task automatic load_settings(input scan_settings_type s);
      put_csr(CSR_DIFFERENTIAL, CSR_DATA_W'(s.diff));
      put_csr(CSR_FIRST_CHAN, CSR_DATA_W'(s.first));
      put_csr(CSR_LAST_CHAN, CSR_DATA_W'(s.last));
      put_csr(CSR_AVG_COUNT, s.avg);
      put_csr(CSR_RESTART, CSR_DATA_W'(s.restart));
      put_csr(CSR_CONTINUOUS, CSR_DATA_W'(s.continuous));
      csr_write_enable <= 1'b0;
      active_cfg = s;
   endtask

   // Offer one item, wait for the handshake, then predict its result.
   task automatic offer_item(input scan_req_type it, input bit typed,
                             input scan_result_type typed_res);
      int              gap;
      scan_result_type res;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 16)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= it.op;
      req_flags_low     <= it.flags_low;
      req_flags_high    <= it.flags_high;
      req_chan          <= it.chan;
      req_sample_first  <= it.sample_first;
      req_sample_second <= it.sample_second;
      do @(posedge clock); while (!req_ready);
      compute_scan_result(it, res);
      pending_results.push_back(typed ? typed_res : res);
   endtask

   // Drop valid and wait until every expected result has come back.
   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------------

   function automatic scan_req_type make_req(input logic [1:0] op, input logic [15:0] fl,
                                             input logic [15:0] fh, input logic [4:0] ch,
                                             input logic [15:0] s0, input logic [15:0] s1);
      scan_req_type r;
      r.op            = op;
      r.flags_low     = fl;
      r.flags_high    = fh;
      r.chan          = ch;
      r.sample_first  = s0;
      r.sample_second = s1;
      return r;
   endfunction

   function automatic scan_result_type make_result(input status_type st, input logic dn,
                                                   input logic rq, input logic [23:0] sm,
                                                   input logic [8:0] ct);
      scan_result_type r;
      r.status  = st;
      r.done    = dn;
      r.restart = rq;
      r.sum     = sm;
      r.count   = ct;
      return r;
   endfunction

   task automatic push_row(input scan_req_type it, input bit typed,
                           input scan_result_type want);
      stim_row_type row;
      row       = '0;
      row.item  = it;
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endtask

   task automatic push_settings(input logic diff, input logic [4:0] first,
                                input logic [4:0] last, input logic [8:0] avg,
                                input logic rst, input logic cont);
      stim_row_type row;
      row                = '0;
      row.is_settings    = 1'b1;
      row.cfg.diff       = diff;
      row.cfg.first      = first;
      row.cfg.last       = last;
      row.cfg.avg        = avg;
      row.cfg.restart    = rst;
      row.cfg.continuous = cont;
      directed_rows.push_back(row);
   endtask

   function automatic scan_req_type random_req();
      return make_req(2'($urandom_range(3)), 16'($urandom), 16'($urandom),
                      5'($urandom_range(31)), 16'($urandom), 16'($urandom));
   endfunction

   // Pick a channel inside the scan range, leaning on the last channel so
   // that averages complete often.
   function automatic logic [4:0] pick_scan_chan();
      if (range_empty())
         return 5'($urandom_range(31));
      if ($urandom_range(99) < 30)
         return 5'(eff_last());
      return 5'($urandom_range(eff_last(), active_cfg.first));
   endfunction

   // Flags item that completes the buffers most of the time.
   function automatic scan_req_type complete_flags();
      scan_req_type r;
      logic [31:0]  m;
      logic [31:0]  all;
      r    = random_req();
      r.op = OP_FLAGS;
      m    = scan_mask();
      if (active_cfg.diff) begin
         if ($urandom_range(99) < 80)
            r.flags_low = m[15:0] | (16'($urandom) & 16'($urandom));
         if ($urandom_range(99) < 80)
            r.flags_high = m[15:0] | (16'($urandom) & 16'($urandom));
      end else begin
         all = m | ($urandom & $urandom);
         // Knock out one bit now and then to leave the scan incomplete.
         if ($urandom_range(99) < 10)
            all[$urandom_range(31)] = 1'b0;
         r.flags_low  = all[15:0];
         r.flags_high = all[31:16];
      end
      return r;
   endfunction

   function automatic scan_settings_type random_settings();
      scan_settings_type s;
      int                pick;
      s.diff = 1'($urandom_range(1));
      if (s.diff && $urandom_range(99) < 75) begin
         s.first = 5'($urandom_range(15));
         s.last  = 5'($urandom_range(15, s.first));
      end else begin
         s.first = 5'($urandom_range(31));
         s.last  = 5'($urandom_range(31, s.first));
      end
      // Occasionally allow an empty range.
      if ($urandom_range(99) < 10)
         s.last = 5'($urandom_range(31));
      pick = $urandom_range(99);
      if (pick < 55)
         s.avg = 9'($urandom_range(4, 1));
      else if (pick < 80)
         s.avg = 9'($urandom_range(16, 5));
      else if (pick < 92)
         s.avg = 9'($urandom_range(256, 17));
      else if (pick < 96)
         s.avg = 9'd0;
      else
         s.avg = 9'($urandom_range(511, 257));
      s.restart    = 1'($urandom_range(1));
      s.continuous = 1'($urandom_range(1));
      return s;
   endfunction

   // Mostly well-formed scans: a completing flags item followed by a burst
   // of samples and reads in range. The rest is noise over the whole space.
   task automatic run_phase(input int budget);
      int           sent;
      int           burst;
      bit           paused;
      scan_req_type it;
      sent   = 0;
      paused = 0;
      while (sent < budget) begin
         if ($urandom_range(99) < 85) begin
            offer_item(complete_flags(), 0, blank_result);
            sent++;
            burst = $urandom_range(12, 1);
            repeat (burst) begin
               it      = random_req();
               it.op   = ($urandom_range(99) < 75) ? OP_SAMPLE : OP_READ;
               it.chan = pick_scan_chan();
               offer_item(it, 0, blank_result);
               sent++;
            end
         end else begin
            it = random_req();
            offer_item(it, 0, blank_result);
            // Spare op only gets an all-zero result from the block; do not count it.
            if (it.op != OP_SPARE)
               sent++;
         end
         // Pause halfway until the block has answered everything.
         if (!paused && sent >= budget / 2) begin
            drain_block();
            paused = 1;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------

   // Stall the receiver at random; a long stall is counted down here so the
   // block backs up into its input while the sender keeps offering.
   always @(posedge clock) begin
      if (long_stall_left > 0) begin
         long_stall_left = long_stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < MAX_PRINTS)
         $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Compare every accepted result with the oldest expectation.
   always @(posedge clock) begin
      scan_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", 32'(rsp_status), 32'(0));
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_average_done !== want.done)
               report_mismatch("average_done", 32'(rsp_average_done), 32'(want.done));
            if (rsp_restart_request !== want.restart)
               report_mismatch("restart_request", 32'(rsp_restart_request),
                               32'(want.restart));
            if (rsp_sum_out !== want.sum)
               report_mismatch("sum_out", 32'(rsp_sum_out), 32'(want.sum));
            if (rsp_count_out !== want.count)
               report_mismatch("count_out", 32'(rsp_count_out), 32'(want.count));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------

   initial begin
      stim_row_type      row;
      scan_settings_type s;

      // Predictor starts from the reset state of the block.
      for (int i = 0; i < NUM_CH; i++) begin
         sum_store[i]            = '0;
         count_less_one_store[i] = '0;
         has_data[i]             = 0;
      end
      buf0_complete      = 0;
      buf1_complete      = 0;
      active_cfg         = '0;
      active_cfg.avg     = 9'd1;

      // Directed part, starting from the reset register values (single-ended,
      // channel 0 only, average of one).
      push_row(make_req(OP_READ, 16'h0, 16'h0, 5'd0, 16'h0, 16'h0), 1,
               make_result(STS_NO_DATA, 0, 0, 24'h0, 9'd0));
      push_row(make_req(OP_READ, 16'h0, 16'h0, 5'd5, 16'h0, 16'h0), 1,
               make_result(STS_OUT_OF_RANGE, 0, 0, 24'h0, 9'd0));
      push_row(make_req(OP_SAMPLE, 16'h0, 16'h0, 5'd0, 16'hFFFF, 16'hFFFF), 1,
               make_result(STS_NO_BUFFER, 0, 0, 24'h0, 9'd0));
      push_row(make_req(OP_SPARE, 16'hFFFF, 16'hFFFF, 5'd0, 16'hFFFF, 16'hFFFF), 1,
               blank_result);
      push_row(make_req(OP_FLAGS, 16'h0, 16'h0, 5'd0, 16'h0, 16'h0), 1,
               make_result(STS_NO_BUFFER, 0, 0, 24'h0, 9'd0));
      push_row(make_req(OP_FLAGS, 16'hFFFF, 16'hFFFF, 5'd0, 16'h0, 16'h0), 1,
               make_result(STS_OK, 0, 0, 24'h0, 9'd0));
      push_row(make_req(OP_SAMPLE, 16'h0, 16'h0, 5'd0, 16'hFFFF, 16'h1234), 1,
               make_result(STS_OK, 1, 0, 24'h00FFFF, 9'd1));
      push_row(make_req(OP_READ, 16'h0, 16'h0, 5'd0, 16'h0, 16'h0), 1,
               make_result(STS_OK, 0, 0, 24'h00FFFF, 9'd1));
      // Differential, low half, longest average.
      push_settings(1, 5'd0, 5'd15, 9'd256, 1, 1);
      push_row(make_req(OP_FLAGS, 16'hFFFF, 16'h0, 5'd0, 16'h0, 16'h0), 1,
               make_result(STS_OK, 0, 0, 24'h0, 9'd0));
      push_row(make_req(OP_SAMPLE, 16'h0, 16'h0, 5'd15, 16'hFFFF, 16'hFFFF), 0, blank_result);
      push_row(make_req(OP_FLAGS, 16'hFFFF, 16'hFFFF, 5'd0, 16'h0, 16'h0), 0, blank_result);
      push_row(make_req(OP_SAMPLE, 16'h0, 16'h0, 5'd15, 16'h0001, 16'h8000), 0, blank_result);
      push_row(make_req(OP_READ, 16'h0, 16'h0, 5'd15, 16'h0, 16'h0), 0, blank_result);
      push_row(make_req(OP_SAMPLE, 16'h0, 16'h0, 5'd16, 16'h1, 16'h1), 1,
               make_result(STS_OUT_OF_RANGE, 0, 0, 24'h0, 9'd0));
      // Differential range above bit 15: no half can ever complete.
      push_settings(1, 5'd16, 5'd31, 9'd1, 0, 1);
      push_row(make_req(OP_FLAGS, 16'hFFFF, 16'hFFFF, 5'd0, 16'h0, 16'h0), 1,
               make_result(STS_NO_BUFFER, 0, 0, 24'h0, 9'd0));
      push_row(make_req(OP_SAMPLE, 16'h0, 16'h0, 5'd20, 16'h1, 16'h1), 1,
               make_result(STS_NO_BUFFER, 0, 0, 24'h0, 9'd0));
      // Empty range: first channel above the last.
      push_settings(0, 5'd20, 5'd10, 9'd1, 1, 0);
      push_row(make_req(OP_FLAGS, 16'hFFFF, 16'hFFFF, 5'd0, 16'h0, 16'h0), 1,
               make_result(STS_NO_BUFFER, 0, 0, 24'h0, 9'd0));
      push_row(make_req(OP_READ, 16'h0, 16'h0, 5'd15, 16'h0, 16'h0), 1,
               make_result(STS_OUT_OF_RANGE, 0, 0, 24'h0, 9'd0));
      // Top channel only, average count of zero acts as one, restart on.
      push_settings(0, 5'd31, 5'd31, 9'd0, 1, 1);
      push_row(make_req(OP_FLAGS, 16'h0, 16'h8000, 5'd0, 16'h0, 16'h0), 1,
               make_result(STS_OK, 0, 0, 24'h0, 9'd0));
      push_row(make_req(OP_SAMPLE, 16'h0, 16'h0, 5'd31, 16'hABCD, 16'h0), 0, blank_result);
      push_row(make_req(OP_SAMPLE, 16'h0, 16'h0, 5'd31, 16'h5555, 16'h0), 0, blank_result);
      // Average count past 256 saturates; the stored sum survives the write.
      push_settings(0, 5'd31, 5'd31, 9'd511, 1, 0);
      push_row(make_req(OP_SAMPLE, 16'h0, 16'h0, 5'd31, 16'h0, 16'h0), 0, blank_result);
      push_row(make_req(OP_READ, 16'h0, 16'h0, 5'd31, 16'h0, 16'h0), 0, blank_result);
      push_row(make_req(OP_SPARE, 16'hFFFF, 16'hFFFF, 5'd31, 16'hFFFF, 16'hFFFF), 1,
               blank_result);

      send_idle_pct = 15;
      recv_idle_pct = 73;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed rows; registers change only once the block is idle.
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_settings) begin
            drain_block();
            load_settings(row.cfg);
         end else begin
            offer_item(row.item, row.typed, row.want);
         end
      end

      // Random phases, each under fresh register settings.
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_block();
         s = random_settings();
         if (p == 0) begin
            s.diff  = 0;
            s.first = 5'd0;
            s.last  = 5'd31;
         end else if (p == 1) begin
            s.diff  = 1;
            s.first = 5'd0;
            s.last  = 5'd15;
         end
         load_settings(s);
         // Sender idles lightly while the receiver idles heavily, then swap,
         // then run flat out.
         if (p < NUM_PHASES / 3) begin
            send_idle_pct = 15;
            recv_idle_pct = 73;
         end else if (p < 2 * NUM_PHASES / 3) begin
            send_idle_pct = 73;
            recv_idle_pct = 15;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (p == STALL_PHASE)
            long_stall_left = STALL_CYCLES;
         run_phase(PHASE_ITEMS);
      end

      drain_block();
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
